>>> src/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

   localparam int BYTE_W    = 8;
   localparam int CAP_W     = 8;
   localparam int UNIT_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_FIRST     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_CAPACITY = 1'd1;

   localparam logic [CAP_W-1:0] CAP_RESET = 8'd96;

   localparam logic [UNIT_W-1:0] SURR_LO   = 16'hD800;
   localparam logic [UNIT_W-1:0] SURR_HI   = 16'hDFFF;
   localparam logic [UNIT_W-1:0] ONE_MAX   = 16'h007F;
   localparam logic [UNIT_W-1:0] TWO_MAX   = 16'h07FF;
   localparam logic [BYTE_W-1:0] LEAD2     = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD3     = 8'hE0;
   localparam logic [BYTE_W-1:0] CONT      = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;
   localparam logic [BYTE_W-1:0] SUBST     = 8'h3F;

   // one converted code unit, waiting to be sent: up to three bytes and an
   // optional terminator after them
   typedef struct packed {
      logic [2:0][BYTE_W-1:0] bytes;
      logic [1:0]             n_bytes;
      logic                   term;
   } job_type;

endpackage

>>> src/utf16_to_utf8_transcoder_unit.sv
// Top level of the UTF-16 to UTF-8 transcoder.
//
//  channel  dir  handshake            payload
//  req_     in   req_tvalid/tready    tdata = data_byte, tlast = last_byte
//  rsp_     out  rsp_tvalid/tready    tdata = out_byte,  tlast = end_of_string
//  csr_     in   csr_valid/ready      csr_index 0 = low_first, 1 = dest_capacity
//
// An input item is taken every cycle while the job queue has room; a code
// unit finished on an item queues 0 to 3 bytes plus an optional terminator.
// The back end sends one result per cycle from its output register while
// rsp_tready is high. Reset is synchronous; csr_ready is always high.
// Output stalls fill the 4-entry job queue before req_tready drops.
module utf16_to_utf8_transcoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] data_byte
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] out_byte
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [u16u8_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [u16u8_pkg::CAP_W-1:0]     csr_data
);
   import u16u8_pkg::*;

   logic    job_push, job_full, job_pop, job_empty;
   job_type push_job, head_job;

   assign csr_ready = 1'b1;

   u16u8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job_full  (job_full),
      .job_push  (job_push),
      .job       (push_job)
   );

   u16u8_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (job_full),
      .pop      (job_pop),
      .empty    (job_empty),
      .head_job (head_job)
   );

   u16u8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .head_job  (head_job),
      .job_pop   (job_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

>>> src/u16u8_front.sv
// Front end: pairs bytes into code units, checks capacity, builds output jobs.
module u16u8_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [u16u8_pkg::BYTE_W-1:0]    in_byte,
   input  logic                            in_last,
   input  logic                            csr_valid,
   input  logic [u16u8_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [u16u8_pkg::CAP_W-1:0]     csr_data,
   input  logic                            job_full,
   output logic                            job_push,
   output u16u8_pkg::job_type              job
);
   import u16u8_pkg::*;

   logic                low_first_ff;
   logic [CAP_W-1:0]    capacity_ff;
   logic [BYTE_W-1:0]   held_ff, held_in;
   logic                have_first_ff, have_first_in;
   logic                stopped_ff, stopped_in;
   logic [CAP_W-1:0]    count_ff, count_in;

   logic                accept;
   logic [UNIT_W-1:0]   unit;
   logic [UNIT_W-1:0]   cp;
   logic [1:0]          size;
   logic [CAP_W:0]      next_pos;
   logic                fits;
   job_type             job_c;

   assign in_ready = !job_full;
   assign accept   = in_valid && in_ready;

   assign unit = low_first_ff ? {in_byte, held_ff} : {held_ff, in_byte};
   assign cp   = (unit >= SURR_LO && unit <= SURR_HI) ? UNIT_W'(SUBST) : unit;

   always_comb begin
      if (cp <= ONE_MAX) begin
         size = 2'd1;
      end else if (cp <= TWO_MAX) begin
         size = 2'd2;
      end else begin
         size = 2'd3;
      end
   end

   assign next_pos = {1'b0, count_ff} + (CAP_W+1)'(size);
   // the character and the terminator after it must both fit
   assign fits     = (capacity_ff != '0) && (next_pos < {1'b0, capacity_ff});

   always_comb begin
      held_in       = held_ff;
      have_first_in = have_first_ff;
      stopped_in    = stopped_ff;
      count_in      = count_ff;
      job_c         = '0;
      if (!have_first_ff) begin
         held_in       = in_byte;
         have_first_in = 1'b1;
      end else begin
         have_first_in = 1'b0;
         if (!stopped_ff) begin
            if (unit == '0) begin
               stopped_in = 1'b1;
            end else if (fits) begin
               count_in      = next_pos[CAP_W-1:0];
               job_c.n_bytes = size;
               unique case (size)
                  2'd1: job_c.bytes[0] = cp[BYTE_W-1:0];
                  2'd2: begin
                     job_c.bytes[0] = LEAD2 | BYTE_W'(cp[10:6]);
                     job_c.bytes[1] = CONT | (cp[BYTE_W-1:0] & CONT_MASK);
                  end
                  default: begin
                     job_c.bytes[0] = LEAD3 | BYTE_W'(cp[15:12]);
                     job_c.bytes[1] = CONT | (cp[13:6] & CONT_MASK);
                     job_c.bytes[2] = CONT | (cp[BYTE_W-1:0] & CONT_MASK);
                  end
               endcase
            end
         end
      end
      if (in_last) begin
         job_c.term    = (capacity_ff != '0);
         held_in       = '0;
         have_first_in = 1'b0;
         stopped_in    = 1'b0;
         count_in      = '0;
      end
   end

   assign job      = job_c;
   assign job_push = accept && (job_c.n_bytes != 2'd0 || job_c.term);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_first_ff  <= 1'b0;
         capacity_ff   <= CAP_RESET;
         held_ff       <= '0;
         have_first_ff <= 1'b0;
         stopped_ff    <= 1'b0;
         count_ff      <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_LOW_FIRST) begin
               low_first_ff <= csr_data[0];
            end
            if (csr_index == CSR_DEST_CAPACITY) begin
               capacity_ff <= csr_data;
            end
         end
         if (accept) begin
            held_ff       <= held_in;
            have_first_ff <= have_first_in;
            stopped_ff    <= stopped_in;
            count_ff      <= count_in;
         end
      end
   end

endmodule

>>> src/u16u8_fifo.sv
// Short job queue between front end and back end.
module u16u8_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  u16u8_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output u16u8_pkg::job_type head_job
);
   import u16u8_pkg::*;

   job_type                 entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [JOB_CNT_W-1:0]    fill_ff, fill_in;
   logic                    do_push, do_pop;

   assign full     = (fill_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> src/u16u8_back.sv
// Back end: sends each job's bytes and terminator one per cycle through an output register while out_ready is high.
module u16u8_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_empty,
   input  u16u8_pkg::job_type           head_job,
   output logic                         job_pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [u16u8_pkg::BYTE_W-1:0] out_byte,
   output logic                         out_last
);
   import u16u8_pkg::*;

   job_type             job_ff;
   logic                busy_ff, busy_in;
   logic [1:0]          idx_ff, idx_in;
   logic                valid_ff, valid_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                last_ff, last_in;

   logic                slot_free;
   logic                emit;
   logic                job_done;
   logic [1:0]          final_idx;

   assign slot_free = !valid_ff || out_ready;
   assign emit      = busy_ff && slot_free;
   // index of the job's last result: bytes, then the terminator if any
   assign final_idx = job_ff.term ? job_ff.n_bytes : job_ff.n_bytes - 2'd1;
   assign job_done  = emit && (idx_ff == final_idx);
   assign job_pop   = !job_empty && (!busy_ff || job_done);

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         idx_in   = idx_ff + 2'd1;
         if (idx_ff < job_ff.n_bytes) begin
            byte_in = job_ff.bytes[idx_ff];
            last_in = 1'b0;
         end else begin
            byte_in = '0;
            last_in = 1'b1;
         end
         if (job_done) begin
            busy_in = 1'b0;
         end
      end
      if (job_pop) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      if (job_pop) begin
         job_ff <= head_job;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

>>> src/u16u8_checker.sv
// Port-level checks for the transcoder, bound to the top level.
module u16u8_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata == 8'h00)
      else $error("terminator not zero");

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata != 8'h00)
      else $error("zero data byte");

   a_no_four_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:4] != 4'hF)
      else $error("four-byte lead in output");

endmodule

bind utf16_to_utf8_transcoder_unit u16u8_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
